[design/nsp_pkg.sv]
// Shared types, register codes and sizing constants for the nine-slice patch generator.
package nsp_pkg;

  // Slices per axis and patches per command.
  localparam int unsigned Slices   = 3;
  localparam int unsigned NumPatch = Slices * Slices;

  // Middle-cut divider: quotient bits, bits retired per cycle, iterations per request.
  localparam int unsigned QuoW     = 24;
  localparam int unsigned DivSteps = 3;
  localparam int unsigned DivIters = QuoW / DivSteps;
  localparam int unsigned DivCntW  = $clog2(DivIters);

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SRC_LEFT   = 3'd0,
    REG_SRC_RIGHT  = 3'd1,
    REG_SRC_TOP    = 3'd2,
    REG_SRC_BOTTOM = 3'd3,
    REG_DST_LEFT   = 3'd4,
    REG_DST_RIGHT  = 3'd5,
    REG_DST_TOP    = 3'd6,
    REG_DST_BOTTOM = 3'd7
  } reg_idx_e;

  // Front sequencer states.
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PREP,
    FS_DIV,
    FS_CUT
  } front_state_e;

  // One draw command request.
  typedef struct packed {
    logic signed [31:0] element_x;
    logic signed [31:0] element_y;
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic signed [31:0] box_width;
    logic signed [31:0] box_height;
    logic [7:0]         alpha;
    logic [15:0]        image_x;
    logic [15:0]        image_y;
    logic [15:0]        image_width;
    logic [15:0]        image_height;
  } cmd_t;

  // One patch request.
  typedef struct packed {
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic [30:0]        dst_width;
    logic [30:0]        dst_height;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [15:0]        src_x;
    logic [15:0]        src_y;
    logic [15:0]        src_width;
    logic [15:0]        src_height;
    logic               last_patch;
  } patch_t;

  // Inset registers.
  typedef struct packed {
    logic [15:0] src_left;
    logic [15:0] src_right;
    logic [15:0] src_top;
    logic [15:0] src_bottom;
    logic [23:0] dst_left;
    logic [23:0] dst_right;
    logic [23:0] dst_top;
    logic [23:0] dst_bottom;
  } cfg_t;

  // Cut set of one command, handed from the front to the back.
  typedef struct packed {
    logic [3:0][31:0]      dx;
    logic [3:0][31:0]      dy;
    logic [3:0][15:0]      sx;
    logic [3:0][15:0]      sy;
    logic [NumPatch-1:0]   mask;
  } cuts_t;

endpackage

[design/nine_slice_patch_generator.sv]
// Top level of the nine-slice patch generator: register port, front and back.
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_stall_o   in_req_i (cmd_t)
//   out       result     out_valid_o / out_stall_i out_patch_o (patch_t)
//   cfg       APB write  psel/penable/pwrite       paddr, pwdata, prdata
//
// The front works on one command at a time: checks and the middle-cut products
// in FS_PREP, then the per-axis 3-bit-per-cycle dividers in FS_DIV, then the
// cuts in FS_CUT. The back emits one patch per cycle while the output is not
// stalled. Reset clears all control state and the inset registers. A two-entry
// queue between front and back absorbs stalls of either side until it fills.
module nine_slice_patch_generator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  nsp_pkg::cmd_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nsp_pkg::patch_t out_patch_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import nsp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_we;
  logic     cuts_valid, cuts_stall;
  cuts_t    cuts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  // Inset registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SRC_LEFT:   cfg_q.src_left   <= pwdata[15:0];
        REG_SRC_RIGHT:  cfg_q.src_right  <= pwdata[15:0];
        REG_SRC_TOP:    cfg_q.src_top    <= pwdata[15:0];
        REG_SRC_BOTTOM: cfg_q.src_bottom <= pwdata[15:0];
        REG_DST_LEFT:   cfg_q.dst_left   <= pwdata[23:0];
        REG_DST_RIGHT:  cfg_q.dst_right  <= pwdata[23:0];
        REG_DST_TOP:    cfg_q.dst_top    <= pwdata[23:0];
        REG_DST_BOTTOM: cfg_q.dst_bottom <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_SRC_LEFT:   prdata = {16'd0, cfg_q.src_left};
      REG_SRC_RIGHT:  prdata = {16'd0, cfg_q.src_right};
      REG_SRC_TOP:    prdata = {16'd0, cfg_q.src_top};
      REG_SRC_BOTTOM: prdata = {16'd0, cfg_q.src_bottom};
      REG_DST_LEFT:   prdata = {8'd0, cfg_q.dst_left};
      REG_DST_RIGHT:  prdata = {8'd0, cfg_q.dst_right};
      REG_DST_TOP:    prdata = {8'd0, cfg_q.dst_top};
      REG_DST_BOTTOM: prdata = {8'd0, cfg_q.dst_bottom};
      default:        prdata = '0;
    endcase
  end

  nsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .cuts_valid_o (cuts_valid),
    .cuts_stall_i (cuts_stall),
    .cuts_o       (cuts)
  );

  nsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cuts_valid_i (cuts_valid),
    .cuts_stall_o (cuts_stall),
    .cuts_i       (cuts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_patch_o  (out_patch_o)
  );

endmodule

[design/nsp_front.sv]
// Front: accepts commands, checks them and computes the cut set of both axes.
module nsp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nsp_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nsp_pkg::cmd_t  in_req_i,
  output logic           cuts_valid_o,
  input  logic           cuts_stall_i,
  output nsp_pkg::cuts_t cuts_o
);
  import nsp_pkg::*;

  front_state_e        state_q, state_d;
  cmd_t                cmd_q;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                drop_q, drop_d;
  logic signed [31:0]  ox_q, oy_q, nx_q, ny_q;
  logic                divx_q, divy_q;
  logic [24:0]         fx_q, fy_q;
  logic [25:0]         remx_q, remx_d, remy_q, remy_d;
  logic [QuoW-1:0]     numx_q, numx_d, numy_q, numy_d;
  logic [QuoW-1:0]     qx_q, qx_d, qy_q, qy_d;

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [26:0] div_step(input logic [25:0] r, input logic b,
                                           input logic [24:0] d);
    logic [25:0] r2;
    logic [26:0] res;
    r2 = {r[24:0], b};
    if (r2 >= {1'b0, d}) res = {1'b1, r2 - {1'b0, d}};
    else                 res = {1'b0, r2};
    return res;
  endfunction

  // Origin and end of each axis, the overflow and size checks, the inset sums and the middle-cut products.
  logic signed [32:0] ox33, oy33;
  logic signed [33:0] nx34, ny34;
  logic               bad_size, bad_range;
  logic [24:0]        fx_c, fy_c;
  logic [48:0]        px, py;

  always_comb begin
    ox33 = 33'(cmd_q.element_x) + 33'(cmd_q.box_x);
    oy33 = 33'(cmd_q.element_y) + 33'(cmd_q.box_y);
    nx34 = 34'(ox33) + 34'(cmd_q.box_width);
    ny34 = 34'(oy33) + 34'(cmd_q.box_height);
    bad_size = (cmd_q.alpha == 8'd0) || cmd_q.box_width[31] || (cmd_q.box_width == 32'sd0)
            || cmd_q.box_height[31] || (cmd_q.box_height == 32'sd0);
    bad_range = (ox33[32] != ox33[31]) || (oy33[32] != oy33[31])
             || !((nx34[33:31] == 3'b000) || (nx34[33:31] == 3'b111))
             || !((ny34[33:31] == 3'b000) || (ny34[33:31] == 3'b111));
    fx_c = {1'b0, cfg_i.dst_left} + {1'b0, cfg_i.dst_right};
    fy_c = {1'b0, cfg_i.dst_top} + {1'b0, cfg_i.dst_bottom};
    px = 49'(cmd_q.box_width[24:0]) * 49'(cfg_i.dst_left);
    py = 49'(cmd_q.box_height[24:0]) * 49'(cfg_i.dst_top);
  end

  // Divider iteration: DivSteps quotient bits per cycle on both axes.
  always_comb begin
    logic [26:0] sx, sy;
    remx_d = remx_q;
    remy_d = remy_q;
    numx_d = numx_q;
    numy_d = numy_q;
    qx_d   = qx_q;
    qy_d   = qy_q;
    for (int i = 0; i < DivSteps; i++) begin
      sx = div_step(remx_d, numx_d[QuoW-1], fx_q);
      sy = div_step(remy_d, numy_d[QuoW-1], fy_q);
      remx_d = sx[25:0];
      remy_d = sy[25:0];
      numx_d = {numx_d[QuoW-2:0], 1'b0};
      numy_d = {numy_d[QuoW-2:0], 1'b0};
      qx_d   = {qx_d[QuoW-2:0], sx[26]};
      qy_d   = {qy_d[QuoW-2:0], sy[26]};
    end
  end

  // Destination cuts of one axis.
  function automatic logic [3:0][31:0] axis_cuts(input logic signed [31:0] o,
      input logic signed [31:0] n, input logic use_div, input logic [QuoW-1:0] q,
      input logic [23:0] lead, input logic [23:0] trail);
    logic signed [33:0] a, b, m;
    logic [3:0][31:0]   c;
    m = 34'(o) + 34'(q);
    a = 34'(o) + 34'(lead);
    if (a > 34'(n)) a = 34'(n);
    b = 34'(n) - 34'(trail);
    if (b < a) b = a;
    c[0] = o;
    c[3] = n;
    if (use_div) begin
      c[1] = m[31:0];
      c[2] = m[31:0];
    end else begin
      c[1] = a[31:0];
      c[2] = b[31:0];
    end
    return c;
  endfunction

  // Final cut set and slice mask.
  cuts_t cuts_c;
  logic [Slices-1:0] row_ok, col_ok;

  always_comb begin
    cuts_c.dx = axis_cuts(ox_q, nx_q, divx_q, qx_q, cfg_i.dst_left, cfg_i.dst_right);
    cuts_c.dy = axis_cuts(oy_q, ny_q, divy_q, qy_q, cfg_i.dst_top, cfg_i.dst_bottom);
    cuts_c.sx[0] = cmd_q.image_x;
    cuts_c.sx[1] = cmd_q.image_x + cfg_i.src_left;
    cuts_c.sx[2] = cmd_q.image_x + cmd_q.image_width - cfg_i.src_right;
    cuts_c.sx[3] = cmd_q.image_x + cmd_q.image_width;
    cuts_c.sy[0] = cmd_q.image_y;
    cuts_c.sy[1] = cmd_q.image_y + cfg_i.src_top;
    cuts_c.sy[2] = cmd_q.image_y + cmd_q.image_height - cfg_i.src_bottom;
    cuts_c.sy[3] = cmd_q.image_y + cmd_q.image_height;
    for (int k = 0; k < Slices; k++) begin
      row_ok[k] = (cuts_c.sy[k+1] != cuts_c.sy[k]) && (cuts_c.dy[k+1] != cuts_c.dy[k]);
      col_ok[k] = (cuts_c.sx[k+1] != cuts_c.sx[k]) && (cuts_c.dx[k+1] != cuts_c.dx[k]);
    end
    for (int r = 0; r < Slices; r++) begin
      for (int c = 0; c < Slices; c++) begin
        cuts_c.mask[r*Slices+c] = row_ok[r] && col_ok[c];
      end
    end
  end

  // Sequencer: next state, handshakes.
  logic finish, accept;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    drop_d       = drop_q;
    cuts_valid_o = 1'b0;
    finish       = 1'b0;
    unique case (state_q)
      FS_IDLE: ;
      FS_PREP: begin
        drop_d  = bad_size || bad_range;
        cnt_d   = '0;
        state_d = FS_DIV;
      end
      FS_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivIters - 1)) state_d = FS_CUT;
      end
      FS_CUT: begin
        cuts_valid_o = !drop_q && (cuts_c.mask != '0);
        finish       = !cuts_valid_o || !cuts_stall_i;
        if (finish) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
    in_stall_o = !((state_q == FS_IDLE) || finish);
    accept     = in_valid_i && !in_stall_o;
    if (accept) state_d = FS_PREP;
  end

  assign cuts_o = cuts_c;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= in_req_i;
    if (state_q == FS_PREP) begin
      ox_q   <= ox33[31:0];
      oy_q   <= oy33[31:0];
      nx_q   <= nx34[31:0];
      ny_q   <= ny34[31:0];
      fx_q   <= fx_c;
      fy_q   <= fy_c;
      divx_q <= (fx_c != '0) && ($unsigned(cmd_q.box_width) <= {7'd0, fx_c});
      divy_q <= (fy_c != '0) && ($unsigned(cmd_q.box_height) <= {7'd0, fy_c});
      remx_q <= {1'b0, px[48:24]};
      remy_q <= {1'b0, py[48:24]};
      numx_q <= px[23:0];
      numy_q <= py[23:0];
      qx_q   <= '0;
      qy_q   <= '0;
    end else if (state_q == FS_DIV) begin
      remx_q <= remx_d;
      remy_q <= remy_d;
      numx_q <= numx_d;
      numy_q <= numy_d;
      qx_q   <= qx_d;
      qy_q   <= qy_d;
    end
  end

endmodule

[design/nsp_back.sv]
// Back: queues cut sets and emits one patch per cycle in row-major order unless the output stalls.
module nsp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cuts_valid_i,
  output logic            cuts_stall_o,
  input  nsp_pkg::cuts_t  cuts_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nsp_pkg::patch_t out_patch_o
);
  import nsp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned SlotW = $clog2(NumPatch);

  // Slot number to row and column.
  function automatic logic [3:0] slot_pos(input logic [SlotW-1:0] s);
    logic [3:0] rc;
    case (s)
      4'd0:    rc = {2'd0, 2'd0};
      4'd1:    rc = {2'd0, 2'd1};
      4'd2:    rc = {2'd0, 2'd2};
      4'd3:    rc = {2'd1, 2'd0};
      4'd4:    rc = {2'd1, 2'd1};
      4'd5:    rc = {2'd1, 2'd2};
      4'd6:    rc = {2'd2, 2'd0};
      4'd7:    rc = {2'd2, 2'd1};
      4'd8:    rc = {2'd2, 2'd2};
      default: rc = {2'd0, 2'd0};
    endcase
    return rc;
  endfunction

  cuts_t               mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  cuts_t               cur_q;
  logic [NumPatch-1:0] mask_q, mask_d;
  logic                out_valid_q;
  patch_t              out_q;

  logic                push, load, adv, emit;
  logic [NumPatch-1:0] low, rest;
  logic [SlotW-1:0]    slot;
  logic [1:0]          row, col;
  logic [3:0]          rc;
  patch_t              patch_c;

  assign cuts_stall_o = (count_q == CntW'(QueueDepth));
  assign push         = cuts_valid_i && !cuts_stall_o;

  // Lowest pending slot of the current command.
  always_comb begin
    low  = mask_q & (~mask_q + 1'b1);
    rest = mask_q & ~low;
    slot = '0;
    for (int i = 0; i < NumPatch; i++) begin
      if (low[i]) slot = SlotW'(i);
    end
    rc  = slot_pos(slot);
    row = rc[3:2];
    col = rc[1:0];
  end

  assign adv  = !out_valid_q || !out_stall_i;
  assign emit = (mask_q != '0) && adv;
  assign load = (count_q != '0) && ((mask_q == '0) || (emit && (rest == '0)));

  always_comb begin
    mask_d = mask_q;
    if (load)      mask_d = mem_q[rd_ptr_q].mask;
    else if (emit) mask_d = rest;
  end

  // Patch fields of the selected slot.
  always_comb begin
    logic [31:0] dw, dh;
    dw = cur_q.dx[col+2'd1] - cur_q.dx[col];
    dh = cur_q.dy[row+2'd1] - cur_q.dy[row];
    patch_c.dst_x      = cur_q.dx[col];
    patch_c.dst_y      = cur_q.dy[row];
    patch_c.dst_width  = dw[30:0];
    patch_c.dst_height = dh[30:0];
    patch_c.end_x      = cur_q.dx[col+2'd1];
    patch_c.end_y      = cur_q.dy[row+2'd1];
    patch_c.src_x      = cur_q.sx[col];
    patch_c.src_y      = cur_q.sy[row];
    patch_c.src_width  = cur_q.sx[col+2'd1] - cur_q.sx[col];
    patch_c.src_height = cur_q.sy[row+2'd1] - cur_q.sy[row];
    patch_c.last_patch = (rest == '0);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (load) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + CntW'(push) - CntW'(load);
      mask_q  <= mask_d;
      if (emit)     out_valid_q <= 1'b1;
      else if (adv) out_valid_q <= 1'b0;
    end
  end

  // Queue storage, current command and output register.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cuts_i;
    if (load) cur_q <= mem_q[rd_ptr_q];
    if (emit) out_q <= patch_c;
  end

  assign out_valid_o = out_valid_q;
  assign out_patch_o = out_q;

endmodule

[design/nsp_checker.sv]
// Port-level checker for the nine-slice patch generator and its bind.
module nsp_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input nsp_pkg::patch_t out_patch_o,
  input logic            pready
);
  import nsp_pkg::*;

  logic [31:0] span_x, span_y;

  assign span_x = out_patch_o.end_x - out_patch_o.dst_x;
  assign span_y = out_patch_o.end_y - out_patch_o.dst_y;

  // A stalled patch stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_patch_o))
    else $error("stalled patch changed");

  // Every patch has a source area.
  a_src_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_patch_o.src_width != 16'd0) && (out_patch_o.src_height != 16'd0))
    else $error("patch with empty source slice");

  // End edges agree with origin plus size.
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (span_x[30:0] == out_patch_o.dst_width)
                 && (span_y[30:0] == out_patch_o.dst_height)
                 && (span_x != 32'd0) && (span_y != 32'd0))
    else $error("patch end does not match its size");

  // The register port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind nine_slice_patch_generator nsp_checker u_nsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_patch_o (out_patch_o),
  .pready      (pready)
);
